@@ hw/rtl/qsd_pkg.sv @@
// ----------------------------------------------------------------------------
// qsd_pkg
// Shared types and constants for the query string decoder.
// ----------------------------------------------------------------------------
package qsd_pkg;

    localparam int unsigned MaxResults = 3;

    typedef enum logic [2:0] {
        MODE_NAME   = 3'd0,
        MODE_VALUE  = 3'd1,
        MODE_HEX_HI = 3'd2,
        MODE_HEX_LO = 3'd3,
        MODE_FAILED = 3'd4
    } mode_t;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NAME  = 2'd0;
    localparam kind_t KIND_VALUE = 2'd1;
    localparam kind_t KIND_END   = 2'd2;
    localparam kind_t KIND_ERROR = 2'd3;

    typedef logic [1:0] err_t;
    localparam err_t ERR_NONE       = 2'd0;
    localparam err_t ERR_NO_EQUALS  = 2'd1;
    localparam err_t ERR_BAD_ESCAPE = 2'd2;

    localparam logic [7:0] CHAR_AMP    = 8'h26;
    localparam logic [7:0] CHAR_QMARK  = 8'h3f;
    localparam logic [7:0] CHAR_EQUALS = 8'h3d;
    localparam logic [7:0] CHAR_PCT    = 8'h25;
    localparam logic [7:0] CHAR_PLUS   = 8'h2b;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_LF     = 8'h0a;
    localparam logic [7:0] CHAR_QUOTE  = 8'h27;
    localparam logic [7:0] CHAR_BSLASH = 8'h5c;
    localparam logic [7:0] CHAR_N      = 8'h6e;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        err_t       code;
    } result_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] acc;
        logic       has_bytes;
    } parse_state_t;

endpackage

@@ hw/rtl/qsd_step.sv @@
// ----------------------------------------------------------------------------
// qsd_step
// Decode of one input byte: next parse state and up to three results.
// ----------------------------------------------------------------------------
module qsd_step (
    input  qsd_pkg::parse_state_t cur,
    input  logic [7:0]            text_byte,
    input  logic                  end_of_text,
    output qsd_pkg::parse_state_t nxt,
    output qsd_pkg::result_t      res [qsd_pkg::MaxResults],
    output logic [1:0]            res_count
);

    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        // bit 4 flags a valid hex digit
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b1, b[3:0]};
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            r = {1'b1, b[3:0] + 4'd9};
        return r;
    endfunction

    function automatic logic needs_escape(input logic [7:0] v);
        return v == qsd_pkg::CHAR_BSLASH || v == qsd_pkg::CHAR_QUOTE
            || v == qsd_pkg::CHAR_LF;
    endfunction

    always_comb
    begin
        logic [7:0] vbyte;
        logic       vemit;
        logic       amp_end;
        logic [4:0] nib;
        logic       in_hex;

        nxt       = cur;
        res_count = 2'd0;
        vbyte     = 8'd0;
        vemit     = 1'b0;
        nib       = hex_nibble(text_byte);
        for (int i = 0; i < qsd_pkg::MaxResults; i++)
        begin
            res[i] = '{data: 8'd0, kind: qsd_pkg::KIND_NAME, code: qsd_pkg::ERR_NONE};
        end

        in_hex  = cur.mode == qsd_pkg::MODE_HEX_HI || cur.mode == qsd_pkg::MODE_HEX_LO;
        amp_end = text_byte == qsd_pkg::CHAR_AMP && !in_hex;

        if (!amp_end)
        begin
            unique case (cur.mode)
                qsd_pkg::MODE_NAME:
                begin
                    if (!cur.has_bytes && text_byte == qsd_pkg::CHAR_QMARK)
                    begin
                        // leading question mark dropped
                    end
                    else if (text_byte == qsd_pkg::CHAR_EQUALS)
                    begin
                        nxt.mode = qsd_pkg::MODE_VALUE;
                    end
                    else
                    begin
                        res[0]    = '{data: text_byte, kind: qsd_pkg::KIND_NAME,
                                      code: qsd_pkg::ERR_NONE};
                        res_count = 2'd1;
                    end
                    nxt.has_bytes = 1'b1;
                end
                qsd_pkg::MODE_VALUE:
                begin
                    if (text_byte == qsd_pkg::CHAR_PCT)
                    begin
                        nxt.mode = qsd_pkg::MODE_HEX_HI;
                    end
                    else
                    begin
                        vemit = 1'b1;
                        vbyte = (text_byte == qsd_pkg::CHAR_PLUS) ? qsd_pkg::CHAR_SPACE
                                                                  : text_byte;
                    end
                end
                qsd_pkg::MODE_HEX_HI:
                begin
                    if (nib[4])
                    begin
                        nxt.acc  = {nib[3:0], 4'd0};
                        nxt.mode = qsd_pkg::MODE_HEX_LO;
                    end
                    else
                    begin
                        res[0]    = '{data: 8'd0, kind: qsd_pkg::KIND_ERROR,
                                      code: qsd_pkg::ERR_BAD_ESCAPE};
                        res_count = 2'd1;
                        nxt.mode  = qsd_pkg::MODE_FAILED;
                    end
                end
                qsd_pkg::MODE_HEX_LO:
                begin
                    if (nib[4])
                    begin
                        vemit    = 1'b1;
                        vbyte    = cur.acc | {4'd0, nib[3:0]};
                        nxt.mode = qsd_pkg::MODE_VALUE;
                    end
                    else
                    begin
                        res[0]    = '{data: 8'd0, kind: qsd_pkg::KIND_ERROR,
                                      code: qsd_pkg::ERR_BAD_ESCAPE};
                        res_count = 2'd1;
                        nxt.mode  = qsd_pkg::MODE_FAILED;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // value bytes: backslash, quote and newline go out as two bytes
        if (vemit)
        begin
            if (needs_escape(vbyte))
            begin
                res[0]    = '{data: qsd_pkg::CHAR_BSLASH, kind: qsd_pkg::KIND_VALUE,
                              code: qsd_pkg::ERR_NONE};
                res[1]    = '{data: (vbyte == qsd_pkg::CHAR_LF) ? qsd_pkg::CHAR_N : vbyte,
                              kind: qsd_pkg::KIND_VALUE, code: qsd_pkg::ERR_NONE};
                res_count = 2'd2;
            end
            else
            begin
                res[0]    = '{data: vbyte, kind: qsd_pkg::KIND_VALUE,
                              code: qsd_pkg::ERR_NONE};
                res_count = 2'd1;
            end
        end

        // pair close on ampersand or at end of text, on the updated state
        if (amp_end || end_of_text)
        begin
            unique case (nxt.mode)
                qsd_pkg::MODE_NAME:
                begin
                    if (nxt.has_bytes)
                    begin
                        res[res_count] = '{data: 8'd0, kind: qsd_pkg::KIND_ERROR,
                                           code: qsd_pkg::ERR_NO_EQUALS};
                        res_count      = res_count + 2'd1;
                        nxt.mode       = qsd_pkg::MODE_FAILED;
                    end
                    else
                    begin
                        nxt.has_bytes = 1'b0;
                    end
                end
                qsd_pkg::MODE_VALUE:
                begin
                    res[res_count] = '{data: 8'd0, kind: qsd_pkg::KIND_END,
                                       code: qsd_pkg::ERR_NONE};
                    res_count      = res_count + 2'd1;
                    nxt.mode       = qsd_pkg::MODE_NAME;
                    nxt.has_bytes  = 1'b0;
                end
                qsd_pkg::MODE_HEX_HI, qsd_pkg::MODE_HEX_LO:
                begin
                    res[res_count] = '{data: 8'd0, kind: qsd_pkg::KIND_ERROR,
                                       code: qsd_pkg::ERR_BAD_ESCAPE};
                    res_count      = res_count + 2'd1;
                    nxt.mode       = qsd_pkg::MODE_FAILED;
                end
                default:
                begin
                end
            endcase
        end

        if (end_of_text)
        begin
            nxt.mode      = qsd_pkg::MODE_NAME;
            nxt.acc       = 8'd0;
            nxt.has_bytes = 1'b0;
        end
    end

endmodule

@@ hw/rtl/query_string_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// query_string_decoder_unit
// Percent decoder for URL query strings, emitting tagged name/value bytes.
//
//   channel  dir  fields
//   s_axis   in   tdata = text_byte, tlast = end_of_text
//   m_axis   out  tdata = out_byte, error_code; tuser = item_kind;
//                 tlast = last_of_run
//
// an input item is decoded in the cycle it is accepted; its results, up to
// three and possibly none, sit in a result buffer and leave one per cycle
// while m_axis_tready is high; a new item is taken in the same cycle
// as the last buffered result, so single-result bytes run at one item
// per cycle when the output never stalls; two- and three-result bytes
// hold the input until drained; reset clears parse state, empties buffer
// ----------------------------------------------------------------------------
module query_string_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] error_code
    output logic [1:0]  m_axis_tuser,   // [1:0] item_kind
    output logic        m_axis_tlast
);

    qsd_pkg::parse_state_t state_reg;
    qsd_pkg::parse_state_t state_next;
    qsd_pkg::result_t      step_res [qsd_pkg::MaxResults];
    logic [1:0]            step_count;

    qsd_pkg::result_t      buf_reg [qsd_pkg::MaxResults];
    logic [1:0]            cnt_reg;
    logic [1:0]            idx_reg;
    logic [1:0]            cnt_next;
    logic [1:0]            idx_next;

    logic                  in_fire;
    logic                  out_fire;
    logic                  at_last;
    qsd_pkg::result_t      cur_res;

    qsd_step u_step (
        .cur         (state_reg),
        .text_byte   (s_axis_tdata),
        .end_of_text (s_axis_tlast),
        .nxt         (state_next),
        .res         (step_res),
        .res_count   (step_count)
    );

    assign cur_res       = buf_reg[idx_reg];
    assign at_last       = idx_reg == (cnt_reg - 2'd1);
    assign m_axis_tvalid = cnt_reg != 2'd0;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (cnt_reg == 2'd0) || (m_axis_tready && at_last);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tdata  = {6'd0, cur_res.code, cur_res.data};
    assign m_axis_tuser  = cur_res.kind;
    assign m_axis_tlast  = at_last;

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (in_fire)
        begin
            cnt_next = step_count;
            idx_next = 2'd0;
        end
        else if (out_fire)
        begin
            if (at_last)
            begin
                cnt_next = 2'd0;
                idx_next = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{mode: qsd_pkg::MODE_NAME, acc: 8'd0, has_bytes: 1'b0};
            cnt_reg   <= 2'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= state_next;
            end
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < qsd_pkg::MaxResults; i++)
            begin
                buf_reg[i] <= step_res[i];
            end
        end
    end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for query_string_decoder_unit: query strings go in byte
// by byte, a scoreboard predicts the tagged name/value/end/error items and
// checks every output item in order, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int ResetCycles = 7;
    localparam int CycleLimit  = 200000;
    localparam int LongHold    = 150;
    localparam int TailCycles  = 16;
    localparam int RandomItems = 260;

    typedef struct {
        logic [7:0]     data;
        qsd_pkg::kind_t kind;
        qsd_pkg::err_t  code;
        logic           last;
    } decoded_item_t;

    class decode_scoreboard;
        qsd_pkg::mode_t mode;
        logic [7:0]     acc;
        logic           has_bytes;
        decoded_item_t  step_q[$];
        decoded_item_t  expected_q[$];
        int             errors;
        int             live_items;

        function new();
            clear_state();
            errors     = 0;
            live_items = 0;
        endfunction

        function void clear_state();
            mode      = qsd_pkg::MODE_NAME;
            acc       = 8'h00;
            has_bytes = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int hex_nibble(logic [7:0] b);
            if (b >= "0" && b <= "9")
                return int'(b - "0");
            if (b >= "a" && b <= "f")
                return int'(b - "a") + 10;
            if (b >= "A" && b <= "F")
                return int'(b - "A") + 10;
            return -1;
        endfunction

        function void push_item(logic [7:0] data, qsd_pkg::kind_t kind,
                                qsd_pkg::err_t code);
            decoded_item_t it;
            it.data = data;
            it.kind = kind;
            it.code = code;
            it.last = 1'b0;
            if (step_q.size() < qsd_pkg::MaxResults)
                step_q.push_back(it);
        endfunction

        // backslash, quote and newline leave as two-byte escapes
        function void push_value(logic [7:0] c);
            if (c == qsd_pkg::CHAR_BSLASH || c == qsd_pkg::CHAR_QUOTE)
            begin
                push_item(qsd_pkg::CHAR_BSLASH, qsd_pkg::KIND_VALUE, qsd_pkg::ERR_NONE);
                push_item(c, qsd_pkg::KIND_VALUE, qsd_pkg::ERR_NONE);
            end
            else if (c == qsd_pkg::CHAR_LF)
            begin
                push_item(qsd_pkg::CHAR_BSLASH, qsd_pkg::KIND_VALUE, qsd_pkg::ERR_NONE);
                push_item(qsd_pkg::CHAR_N, qsd_pkg::KIND_VALUE, qsd_pkg::ERR_NONE);
            end
            else
                push_item(c, qsd_pkg::KIND_VALUE, qsd_pkg::ERR_NONE);
        endfunction

        function void fail_pair(qsd_pkg::err_t code);
            push_item(8'h00, qsd_pkg::KIND_ERROR, code);
            mode = qsd_pkg::MODE_FAILED;
        endfunction

        function void close_pair();
            if (mode == qsd_pkg::MODE_NAME && has_bytes)
                fail_pair(qsd_pkg::ERR_NO_EQUALS);
            else if (mode == qsd_pkg::MODE_HEX_HI || mode == qsd_pkg::MODE_HEX_LO)
                fail_pair(qsd_pkg::ERR_BAD_ESCAPE);
            else if (mode == qsd_pkg::MODE_NAME || mode == qsd_pkg::MODE_VALUE)
            begin
                if (mode == qsd_pkg::MODE_VALUE)
                    push_item(8'h00, qsd_pkg::KIND_END, qsd_pkg::ERR_NONE);
                mode      = qsd_pkg::MODE_NAME;
                has_bytes = 1'b0;
            end
        endfunction

        function void note_input(logic [7:0] b, logic eot);
            int nib;
            bit closed;
            closed = 1'b0;
            step_q.delete();
            if (mode != qsd_pkg::MODE_FAILED)
                live_items++;
            if (b == qsd_pkg::CHAR_AMP && mode != qsd_pkg::MODE_HEX_HI
                && mode != qsd_pkg::MODE_HEX_LO)
            begin
                close_pair();
                closed = 1'b1;
            end
            else
            begin
                case (mode)
                    qsd_pkg::MODE_NAME:
                    begin
                        // a leading question mark of a pair is dropped
                        if (has_bytes || b != qsd_pkg::CHAR_QMARK)
                        begin
                            if (b == qsd_pkg::CHAR_EQUALS)
                                mode = qsd_pkg::MODE_VALUE;
                            else
                                push_item(b, qsd_pkg::KIND_NAME, qsd_pkg::ERR_NONE);
                        end
                        has_bytes = 1'b1;
                    end
                    qsd_pkg::MODE_VALUE:
                    begin
                        if (b == qsd_pkg::CHAR_PCT)
                            mode = qsd_pkg::MODE_HEX_HI;
                        else if (b == qsd_pkg::CHAR_PLUS)
                            push_value(qsd_pkg::CHAR_SPACE);
                        else
                            push_value(b);
                    end
                    qsd_pkg::MODE_HEX_HI:
                    begin
                        nib = hex_nibble(b);
                        if (nib < 0)
                            fail_pair(qsd_pkg::ERR_BAD_ESCAPE);
                        else
                        begin
                            acc  = {nib[3:0], 4'h0};
                            mode = qsd_pkg::MODE_HEX_LO;
                        end
                    end
                    qsd_pkg::MODE_HEX_LO:
                    begin
                        nib = hex_nibble(b);
                        if (nib < 0)
                            fail_pair(qsd_pkg::ERR_BAD_ESCAPE);
                        else
                        begin
                            push_value(acc | {4'h0, nib[3:0]});
                            mode = qsd_pkg::MODE_VALUE;
                        end
                    end
                    default: ;
                endcase
            end
            if (eot)
            begin
                if (!closed)
                    close_pair();
                clear_state();
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i])
                expected_q.push_back(step_q[i]);
        endfunction

        function void check_result(logic [7:0] data, qsd_pkg::kind_t kind,
                                   qsd_pkg::err_t code, logic last);
            decoded_item_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected item data=%h kind=%0d code=%0d last=%b",
                         $time, data, kind, code, last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (want.data !== data)
            begin
                $display("%0t: out_byte expected %h actual %h", $time, want.data, data);
                errors++;
            end
            if (want.kind !== kind)
            begin
                $display("%0t: item_kind expected %0d actual %0d", $time, want.kind, kind);
                errors++;
            end
            if (want.code !== code)
            begin
                $display("%0t: error_code expected %0d actual %0d", $time, want.code, code);
                errors++;
            end
            if (want.last !== last)
            begin
                $display("%0t: last_of_run expected %b actual %b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    decode_scoreboard sb = new();

    logic [7:0] text_q[$];
    int         burst_left = 0;
    bit         long_hold_req = 1'b0;
    int         cycle_count = 0;

    query_string_decoder_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[9:8],
                                m_axis_tlast);
        end
    end

    // output side: stall pattern picked at random from four styles, plus long holds
    initial
    begin
        int style;
        int span;
        style = 0;
        span  = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LongHold) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    style = $urandom_range(0, 3);
                    span  = $urandom_range(20, 80);
                end
                span--;
                case (style)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= (span % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= 8'($urandom);
                s_axis_tlast  <= 1'($urandom_range(0, 1));
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [7:0] hex_char(int v);
        if (v < 10)
            return 8'("0" + v);
        return ($urandom_range(0, 1) == 0) ? 8'("a" + v - 10) : 8'("A" + v - 10);
    endfunction

    function automatic logic [7:0] pick_byte(logic [7:0] skip_a, logic [7:0] skip_b);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == skip_a || b == skip_b);
        return b;
    endfunction

    // mostly well-formed pairs with random content, some broken pairs
    task automatic build_query();
        int npairs;
        int n;
        int r;
        logic [7:0] b;
        text_q.delete();
        npairs = $urandom_range(1, 4);
        for (int p = 0; p < npairs; p++)
        begin
            if ($urandom_range(0, 7) == 0)
                text_q.push_back(qsd_pkg::CHAR_AMP);
            if ($urandom_range(0, 7) == 0)
                text_q.push_back(qsd_pkg::CHAR_QMARK);
            n = $urandom_range(0, 3);
            repeat (n) text_q.push_back(pick_byte(qsd_pkg::CHAR_AMP, qsd_pkg::CHAR_EQUALS));
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: text_q.push_back(pick_byte(qsd_pkg::CHAR_AMP, qsd_pkg::CHAR_EQUALS));
                    1:
                    begin
                        text_q.push_back(qsd_pkg::CHAR_EQUALS);
                        text_q.push_back(qsd_pkg::CHAR_PCT);
                        do
                            b = 8'($urandom_range(0, 255));
                        while (sb.hex_nibble(b) >= 0);
                        text_q.push_back(b);
                    end
                    2:
                    begin
                        text_q.push_back(qsd_pkg::CHAR_EQUALS);
                        text_q.push_back(qsd_pkg::CHAR_PCT);
                        if ($urandom_range(0, 1) == 1)
                            text_q.push_back(hex_char($urandom_range(0, 15)));
                    end
                    default: text_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            else
            begin
                text_q.push_back(qsd_pkg::CHAR_EQUALS);
                n = $urandom_range(0, 5);
                repeat (n)
                begin
                    r = $urandom_range(0, 15);
                    case (r)
                        6: text_q.push_back(qsd_pkg::CHAR_PLUS);
                        7, 8, 9:
                        begin
                            text_q.push_back(qsd_pkg::CHAR_PCT);
                            text_q.push_back(hex_char($urandom_range(0, 15)));
                            text_q.push_back(hex_char($urandom_range(0, 15)));
                        end
                        10: text_q.push_back(qsd_pkg::CHAR_BSLASH);
                        11: text_q.push_back(qsd_pkg::CHAR_QUOTE);
                        12: text_q.push_back(qsd_pkg::CHAR_LF);
                        13: text_q.push_back(qsd_pkg::CHAR_EQUALS);
                        default:
                            text_q.push_back(pick_byte(qsd_pkg::CHAR_AMP, qsd_pkg::CHAR_PCT));
                    endcase
                end
            end
            if (p < npairs - 1 || $urandom_range(0, 3) == 0)
                text_q.push_back(qsd_pkg::CHAR_AMP);
        end
    endtask

    initial
    begin
        bit pressed;
        bit paused;
        int target;
        pressed = 1'b0;
        paused  = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // leading '?', zero and all-ones bytes, escapes of both cases, two-byte
        // escapes raw and decoded, empty pair, end of text right after a backslash
        text_q = '{qsd_pkg::CHAR_QMARK, 8'h00, qsd_pkg::CHAR_EQUALS,
                   qsd_pkg::CHAR_PCT, "5", "c", qsd_pkg::CHAR_LF,
                   qsd_pkg::CHAR_PCT, "0", "A", qsd_pkg::CHAR_AMP,
                   qsd_pkg::CHAR_AMP, 8'hff, qsd_pkg::CHAR_EQUALS,
                   qsd_pkg::CHAR_PLUS, qsd_pkg::CHAR_QUOTE, qsd_pkg::CHAR_BSLASH};
        send_text();
        // pair of only '?' lacks equals, then the rest is ignored
        text_q = '{qsd_pkg::CHAR_QMARK, qsd_pkg::CHAR_AMP, "x"};
        send_text();
        // ampersand where a hex digit is due
        text_q = '{qsd_pkg::CHAR_EQUALS, qsd_pkg::CHAR_PCT, qsd_pkg::CHAR_AMP, "g"};
        send_text();
        // text ends inside an escape
        text_q = '{qsd_pkg::CHAR_EQUALS, qsd_pkg::CHAR_PCT, "f"};
        send_text();
        wait_drained();

        target = sb.live_items + RandomItems;
        while (sb.live_items < target)
        begin
            if (!pressed && sb.live_items > target - RandomItems / 2)
            begin
                // output held off while input keeps coming, so the block backs up
                long_hold_req = 1'b1;
                burst_left    = 40;
                pressed       = 1'b1;
            end
            if (!paused && sb.live_items > target - RandomItems / 4)
            begin
                wait_drained();
                paused = 1'b1;
            end
            build_query();
            send_text();
        end

        wait_drained();
        repeat (TailCycles) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
